### rtl/core/dqr_pkg.sv
// Package for the fixed-answer DNS responder: sizes, protocol constants,
// the request descriptor passed from parser to emitter, and the answer record table.
// No dependencies.
package dqr_pkg;

  localparam int MESSAGE_BUFFER = 512;
  localparam int POS_W          = 10;
  localparam logic [POS_W-1:0] LEN_LIMIT = POS_W'(MESSAGE_BUFFER - 16);
  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [POS_W-1:0] NAME_START = POS_W'(12);

  localparam logic [7:0] QR_MASK        = 8'h80;
  localparam logic [7:0] LABEL_PTR_MASK = 8'hC0;
  localparam logic [7:0] RESP_FLAGS     = 8'h84;
  localparam logic [2:0] TAIL_BYTES     = 3'd4;

  localparam int ANSWER_LEN = 16;
  localparam int AIDX_W     = 4;

  // one accepted input byte expands into this descriptor
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data_byte;
    logic        has_answer;
    logic        has_verdict;
    logic        verdict_accept;
    logic [31:0] query_total;
    logic [31:0] answer_total;
  } job_t;

  // A record: name pointer, type A, class IN, TTL 60, rdlength 4, address
  function automatic logic [7:0] answer_byte(input logic [AIDX_W-1:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hC0;
      4'd1:    v = 8'h0C;
      4'd2:    v = 8'h00;
      4'd3:    v = 8'h01;
      4'd4:    v = 8'h00;
      4'd5:    v = 8'h01;
      4'd6:    v = 8'h00;
      4'd7:    v = 8'h00;
      4'd8:    v = 8'h00;
      4'd9:    v = 8'h3C;
      4'd10:   v = 8'h00;
      4'd11:   v = 8'h04;
      4'd12:   v = addr[31:24];
      4'd13:   v = addr[23:16];
      4'd14:   v = addr[15:8];
      4'd15:   v = addr[7:0];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/dqr_parse.sv
// Query parser: per-packet parse state, header rewrite, name walk and
// wrapping packet counters. Builds one dqr_pkg::job_t per accepted byte.
// Depends on dqr_pkg.
module dqr_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  input  logic             end_of_packet,
  output dqr_pkg::job_t    job
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_TAIL    = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  logic [dqr_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [dqr_pkg::POS_W-1:0] next_label_position, next_label_position_next;
  logic [2:0]                parse_phase, parse_phase_next;
  logic [2:0]                tail_remaining, tail_remaining_next;
  logic                      reject_flag, reject_flag_next;
  logic [31:0]               queries_seen, queries_seen_next;
  logic [31:0]               answers_sent, answers_sent_next;

  logic [dqr_pkg::POS_W:0]   label_jump;
  logic [7:0]                hdr_val;
  logic                      acc;

  assign label_jump = {1'b0, byte_position} + {3'b000, in_byte} + 11'd1;

  always_comb begin
    byte_position_next       = byte_position;
    next_label_position_next = next_label_position;
    parse_phase_next         = parse_phase;
    tail_remaining_next      = tail_remaining;
    reject_flag_next         = reject_flag;
    queries_seen_next        = queries_seen;
    answers_sent_next        = answers_sent;
    hdr_val                  = in_byte;
    acc                      = 1'b0;
    job                      = '0;

    if (byte_position >= dqr_pkg::LEN_LIMIT) begin
      reject_flag_next = 1'b1;
      parse_phase_next = PH_DISCARD;
    end

    case (parse_phase_next)
      PH_HEADER: begin
        case (byte_position)
          10'd2: begin
            if ((in_byte & dqr_pkg::QR_MASK) != 8'h00) begin
              reject_flag_next = 1'b1;
              parse_phase_next = PH_DISCARD;
            end
            hdr_val = dqr_pkg::RESP_FLAGS;
          end
          10'd3: hdr_val = 8'h00;
          10'd4: begin
            if (in_byte != 8'h00) begin
              reject_flag_next = 1'b1;
              parse_phase_next = PH_DISCARD;
            end
          end
          10'd5: begin
            if (in_byte != 8'h01) begin
              reject_flag_next = 1'b1;
              parse_phase_next = PH_DISCARD;
            end
          end
          10'd7:   hdr_val = 8'h01;
          default: begin
            if (byte_position >= 10'd6) hdr_val = 8'h00;
          end
        endcase
        if (parse_phase_next == PH_HEADER) begin
          job.has_byte  = 1'b1;
          job.data_byte = hdr_val;
          if (byte_position >= 10'd11) parse_phase_next = PH_NAME;
        end
      end
      PH_NAME: begin
        if (byte_position == next_label_position) begin
          if (in_byte == 8'h00) begin
            parse_phase_next    = PH_TAIL;
            tail_remaining_next = dqr_pkg::TAIL_BYTES;
          end else if ((in_byte & dqr_pkg::LABEL_PTR_MASK) != 8'h00) begin
            reject_flag_next = 1'b1;
            parse_phase_next = PH_DISCARD;
          end else begin
            next_label_position_next = label_jump[dqr_pkg::POS_W] ? dqr_pkg::POS_MAX
                                       : label_jump[dqr_pkg::POS_W-1:0];
          end
        end
        if (parse_phase_next != PH_DISCARD) begin
          job.has_byte  = 1'b1;
          job.data_byte = in_byte;
        end
      end
      PH_TAIL: begin
        job.has_byte        = 1'b1;
        job.data_byte       = in_byte;
        tail_remaining_next = tail_remaining - 3'd1;
        if (tail_remaining_next == 3'd0) begin
          job.has_answer   = 1'b1;
          parse_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase

    byte_position_next = (byte_position != dqr_pkg::POS_MAX) ? byte_position + 10'd1
                         : dqr_pkg::POS_MAX;

    if (end_of_packet) begin
      acc               = !reject_flag_next && (parse_phase_next == PH_DONE);
      queries_seen_next = queries_seen + 32'd1;
      if (acc) answers_sent_next = answers_sent + 32'd1;
      job.has_verdict    = 1'b1;
      job.verdict_accept = acc;
      job.query_total    = queries_seen_next;
      job.answer_total   = answers_sent_next;
      byte_position_next       = '0;
      next_label_position_next = dqr_pkg::NAME_START;
      parse_phase_next         = PH_HEADER;
      tail_remaining_next      = dqr_pkg::TAIL_BYTES;
      reject_flag_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      next_label_position <= dqr_pkg::NAME_START;
      parse_phase         <= PH_HEADER;
      tail_remaining      <= dqr_pkg::TAIL_BYTES;
      reject_flag         <= 1'b0;
      queries_seen        <= '0;
      answers_sent        <= '0;
    end else if (in_fire) begin
      byte_position       <= byte_position_next;
      next_label_position <= next_label_position_next;
      parse_phase         <= parse_phase_next;
      tail_remaining      <= tail_remaining_next;
      reject_flag         <= reject_flag_next;
      queries_seen        <= queries_seen_next;
      answers_sent        <= answers_sent_next;
    end
  end

  a_tail_range: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_TAIL |-> (tail_remaining != 3'd0 && tail_remaining <= 3'd4))
    else $error("tail count out of range in tail phase");

  a_discard_rejects: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DISCARD |-> reject_flag)
    else $error("discard phase without reject flag");

  a_answer_done: assert property (@(posedge clk) disable iff (rst)
    (in_fire && job.has_answer && !end_of_packet) |=> parse_phase == PH_DONE)
    else $error("answer appended but parser not done");

endmodule

### rtl/core/dqr_emit.sv
// Result emitter: holds one request descriptor and walks it out as
// data bytes, the 16-byte answer record and the verdict item.
// Depends on dqr_pkg.
module dqr_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  dqr_pkg::job_t  job_in,
  input  logic [31:0]    server_address,
  output logic           free,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [79:0]    m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);

  localparam logic [1:0] SEG_BYTE    = 2'd0;
  localparam logic [1:0] SEG_ANSWER  = 2'd1;
  localparam logic [1:0] SEG_VERDICT = 2'd2;

  dqr_pkg::job_t               job_q;
  logic                        busy;
  logic [1:0]                  seg;
  logic [dqr_pkg::AIDX_W-1:0]  idx;
  logic                        is_last;
  logic                        out_fire;
  logic [7:0]                  cur_byte;

  always_comb begin
    case (seg)
      SEG_BYTE:    is_last = !job_q.has_answer && !job_q.has_verdict;
      SEG_ANSWER:  is_last = (idx == dqr_pkg::AIDX_W'(dqr_pkg::ANSWER_LEN - 1))
                             && !job_q.has_verdict;
      default:     is_last = 1'b1;
    endcase
    case (seg)
      SEG_BYTE:    cur_byte = job_q.data_byte;
      SEG_ANSWER:  cur_byte = dqr_pkg::answer_byte(idx, server_address);
      default:     cur_byte = 8'h00;
    endcase
  end

  assign out_fire = busy && m_tready;
  assign free     = !busy || (is_last && m_tready);
  assign m_tvalid = busy;
  assign m_tuser  = (seg == SEG_VERDICT);
  assign m_tlast  = is_last;
  // verdict fields are zero on data items
  assign m_tdata  = {7'd0,
                     (seg == SEG_VERDICT) ? job_q.answer_total : 32'd0,
                     (seg == SEG_VERDICT) ? job_q.query_total  : 32'd0,
                     (seg == SEG_VERDICT) && job_q.verdict_accept,
                     cur_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seg  <= SEG_BYTE;
      idx  <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      seg   <= job_in.has_byte ? SEG_BYTE : SEG_VERDICT;
      idx   <= '0;
    end else if (out_fire) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        case (seg)
          SEG_BYTE: begin
            if (job_q.has_answer) begin
              seg <= SEG_ANSWER;
              idx <= '0;
            end else begin
              seg <= SEG_VERDICT;
            end
          end
          SEG_ANSWER: begin
            if (idx == dqr_pkg::AIDX_W'(dqr_pkg::ANSWER_LEN - 1)) seg <= SEG_VERDICT;
            else idx <= idx + dqr_pkg::AIDX_W'(1);
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_q <= job_in;
  end

  a_answer_present: assert property (@(posedge clk) disable iff (rst)
    (busy && seg == SEG_ANSWER) |-> job_q.has_answer)
    else $error("answer segment without answer request");

  a_byte_present: assert property (@(posedge clk) disable iff (rst)
    (busy && seg == SEG_BYTE) |-> job_q.has_byte)
    else $error("byte segment without data byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && !m_tready) |=> (busy && $stable(seg) && $stable(idx)))
    else $error("emitter advanced while stalled");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("descriptor loaded over pending results");

endmodule

### rtl/core/dns_query_fixed_answer_responder.sv
// Top level of the fixed-answer DNS responder: config register, parser
// and result emitter. Depends on dqr_pkg, dqr_parse, dqr_emit.
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid/s_tready    s_tdata[7:0] in_byte, s_tlast end_of_packet
// m_*       out        m_tvalid/m_tready    m_tdata, m_tuser kind, m_tlast run_last
// cfg_*     in         cfg_valid/cfg_ready  cfg_data server_address
//
// Each input byte is parsed in the cycle it is accepted; its results leave from the emitter
// one per cycle while m_tready is high, so one-result bytes stream at one per cycle unstalled.
// The byte that completes QTYPE/QCLASS yields 17 or 18 results and holds
// s_tready low until the emitter reaches its last result.
// rst is synchronous; the config port is always ready.
module dns_query_fixed_answer_responder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] out_byte, [8] accept, [40:9] query_total,
                                 // [72:41] answer_total, [79:73] zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]   server_address;
  logic          in_fire;
  logic          free;
  dqr_pkg::job_t job;
  logic          load;

  assign cfg_ready = 1'b1;
  assign s_tready  = free;
  assign in_fire   = s_tvalid && s_tready;
  assign load      = in_fire && (job.has_byte || job.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      server_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      server_address <= cfg_data;
    end
  end

  dqr_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .in_fire       (in_fire),
    .in_byte       (s_tdata),
    .end_of_packet (s_tlast),
    .job           (job)
  );

  dqr_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .job_in         (job),
    .server_address (server_address),
    .free           (free),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

endmodule
